FILE: hw/rtl/longest_subsequence_counter_defines.svh
// Assertion macros shared by the longest subsequence counter RTL.
`ifndef LONGEST_SUBSEQUENCE_COUNTER_DEFINES_SVH
`define LONGEST_SUBSEQUENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lsc_pkg.sv
// Package with constants, state type and modular add for the longest subsequence counter.
package lsc_pkg;

    localparam int VALUE_BITS_DEF  = 14;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int COUNT_BITS      = 30;

    localparam logic [COUNT_BITS-1:0] COUNT_MOD = 30'd1000000007;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QLO,
        ST_QHI,
        ST_LEAF_RD,
        ST_LEAF_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_DONE
    } lsc_state_t;

    function automatic logic [COUNT_BITS-1:0] add_mod(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] b
    );
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_MOD})
        begin
            s = s - {1'b0, COUNT_MOD};
        end
        return s[COUNT_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/longest_subsequence_counter.sv
// Longest non-decreasing subsequence counter built around a max-tree held in node memory.
//
// Each input transaction carries one signed value and a last flag; each produces one output
// transaction with the best subsequence length seen so far, its count modulo 1000000007, and
// the last flag. The max-tree lives in one node memory of 2^(VALUE_BITS+1) entries with one
// write port and one registered read port, so tree accesses are made one at a time: the prefix
// query reads each tree level in a QLO and a QHI step, and the leaf-to-root update reads and
// writes each level in an UP_RD and an UP_WR step. A new input is taken only once the result
// of the last one has been placed in the output register, one item at a time. A result that
// is still waiting in the output register holds back the next one. After reset, and after
// every transaction with tlast set, the memory is swept to zero one entry per cycle over all
// 2^(VALUE_BITS+1) entries; no input is accepted during the sweep, while a finished result
// can still be taken.
`include "longest_subsequence_counter_defines.svh"

module longest_subsequence_counter
    import lsc_pkg::*;
#(
    parameter int VALUE_BITS  = VALUE_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    // Fields from bit 0: value.
    input  logic [((VALUE_BITS+7)/8)*8-1:0]                  s_axis_tdata,
    // Field: is_final.
    input  logic                                             s_axis_tlast,
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    // Fields from bit 0: best_length, best_count.
    output logic [((LENGTH_BITS+COUNT_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // Field: sequence_done.
    output logic                                             m_axis_tlast
);

    localparam int NODE_BITS = VALUE_BITS + 1;
    localparam int QW        = VALUE_BITS + 2;
    localparam int NODE_W    = LENGTH_BITS + COUNT_BITS;
    localparam int OUT_W     = ((LENGTH_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int DEPTH     = 2 ** NODE_BITS;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
    localparam logic [QW-1:0]          LEAF_BASE = {2'b01, {VALUE_BITS{1'b0}}};

    function automatic logic [NODE_W-1:0] merge_nodes(
        input logic [NODE_W-1:0] a,
        input logic [NODE_W-1:0] b
    );
        logic [LENGTH_BITS-1:0] al;
        logic [LENGTH_BITS-1:0] bl;
        logic [NODE_W-1:0]      r;
        al = a[LENGTH_BITS-1:0];
        bl = b[LENGTH_BITS-1:0];
        if (al > bl)
        begin
            r = a;
        end
        else if (al < bl)
        begin
            r = b;
        end
        else
        begin
            r = {add_mod(a[NODE_W-1:LENGTH_BITS], b[NODE_W-1:LENGTH_BITS]), al};
        end
        return r;
    endfunction

    logic [NODE_W-1:0] node_mem [DEPTH];

    lsc_state_t state_reg, state_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic [NODE_BITS-1:0]   clr_reg, clr_next;
    logic [QW-1:0]          lo_reg, lo_next;
    logic [QW-1:0]          hi_reg, hi_next;
    logic [NODE_W-1:0]      acc_reg, acc_next;
    logic [NODE_W-1:0]      hold_reg, hold_next;
    logic [NODE_BITS-1:0]   p_reg, p_next;
    logic [VALUE_BITS-1:0]  idx_reg, idx_next;
    logic                   fin_reg, fin_next;
    logic [NODE_W-1:0]      out_node_reg, out_node_next;
    logic                   out_last_reg, out_last_next;

    logic                   mem_we;
    logic [NODE_BITS-1:0]   mem_waddr;
    logic [NODE_W-1:0]      mem_wdata;
    logic                   mem_re;
    logic [NODE_BITS-1:0]   mem_raddr;
    logic [NODE_W-1:0]      mem_rdata_reg;

    logic [QW-1:0]          hi_dec;
    logic [LENGTH_BITS-1:0] acc_len;
    logic [LENGTH_BITS-1:0] new_len;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [NODE_W-1:0]      leaf_node;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= node_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        acc_reg      <= acc_next;
        hold_reg     <= hold_next;
        p_reg        <= p_next;
        idx_reg      <= idx_next;
        fin_reg      <= fin_next;
        out_node_reg <= out_node_next;
        out_last_reg <= out_last_next;
    end

    assign hi_dec  = hi_reg - QW'(1);
    assign acc_len = acc_reg[LENGTH_BITS-1:0];

    always_comb
    begin
        if (acc_len != '0)
        begin
            new_len = (acc_len == LEN_MAX) ? LEN_MAX : acc_len + LENGTH_BITS'(1);
            new_cnt = acc_reg[NODE_W-1:LENGTH_BITS];
        end
        else
        begin
            new_len = LENGTH_BITS'(1);
            new_cnt = COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        if (mem_rdata_reg[LENGTH_BITS-1:0] == hold_reg[LENGTH_BITS-1:0])
        begin
            leaf_node = {add_mod(mem_rdata_reg[NODE_W-1:LENGTH_BITS],
                                 hold_reg[NODE_W-1:LENGTH_BITS]),
                         hold_reg[LENGTH_BITS-1:0]};
        end
        else
        begin
            leaf_node = hold_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;
        clr_next       = clr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        p_next         = p_reg;
        idx_next       = idx_reg;
        fin_next       = fin_reg;
        out_node_next  = out_node_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (pend_reg)
        begin
            acc_next = merge_nodes(acc_reg, mem_rdata_reg);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + NODE_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_next   = {~s_axis_tdata[VALUE_BITS-1], s_axis_tdata[VALUE_BITS-2:0]};
                    fin_next   = s_axis_tlast;
                    acc_next   = '0;
                    lo_next    = LEAF_BASE;
                    hi_next    = LEAF_BASE + {2'b00, ~s_axis_tdata[VALUE_BITS-1],
                                              s_axis_tdata[VALUE_BITS-2:0]} + QW'(1);
                    state_next = ST_QLO;
                end
            end
            ST_QLO:
            begin
                if (lo_reg >= hi_reg)
                begin
                    state_next = ST_LEAF_RD;
                end
                else
                begin
                    if (lo_reg[0])
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = lo_reg[NODE_BITS-1:0];
                        pend_next = 1'b1;
                        lo_next   = lo_reg + QW'(1);
                    end
                    state_next = ST_QHI;
                end
            end
            ST_QHI:
            begin
                if (hi_reg[0])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = hi_dec[NODE_BITS-1:0];
                    pend_next = 1'b1;
                end
                lo_next    = lo_reg >> 1;
                hi_next    = hi_reg >> 1;
                state_next = ST_QLO;
            end
            ST_LEAF_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {1'b1, idx_reg};
                hold_next  = {new_cnt, new_len};
                state_next = ST_LEAF_WR;
            end
            ST_LEAF_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {1'b1, idx_reg};
                mem_wdata  = leaf_node;
                hold_next  = leaf_node;
                p_next     = {1'b1, idx_reg};
                state_next = ST_UP_RD;
            end
            ST_UP_RD:
            begin
                if (p_reg == NODE_BITS'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {p_reg[NODE_BITS-1:1], ~p_reg[0]};
                    state_next = ST_UP_WR;
                end
            end
            ST_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {1'b0, p_reg[NODE_BITS-1:1]};
                mem_wdata  = merge_nodes(hold_reg, mem_rdata_reg);
                hold_next  = merge_nodes(hold_reg, mem_rdata_reg);
                p_next     = {1'b0, p_reg[NODE_BITS-1:1]};
                state_next = ST_UP_RD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = hold_reg;
                    out_last_next  = fin_reg;
                    clr_next       = '0;
                    state_next     = fin_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_node_reg);
    assign m_axis_tlast  = out_last_reg;

    `LSC_ASSERT_IMPL(a_no_rw_overlap, clk, rst_n, mem_we, !mem_re,
        "Node memory written and read in the same cycle.")
    `LSC_ASSERT_IMPL(a_pend_in_query, clk, rst_n, pend_reg,
        state_reg == ST_QLO || state_reg == ST_QHI,
        "Query read returned outside the prefix walk.")
    `LSC_ASSERT_NEXT(a_accept_starts_query, clk, rst_n, s_axis_tvalid && s_axis_tready,
        state_reg == ST_QLO, "Accepted transaction did not start the prefix walk.")
    `LSC_ASSERT_IMPL(a_root_count_reduced, clk, rst_n, state_reg == ST_DONE,
        hold_reg[NODE_W-1:LENGTH_BITS] < COUNT_MOD, "Root count not reduced.")

endmodule
